/* rtl/hsog_pkg.sv */
// ----------------------------------------------------------------------------
// hsog_pkg
// shared types and constants of the hue and saturation object gate
// ----------------------------------------------------------------------------
`default_nettype none

package hsog_pkg;

    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned HUE_DEG_W  = 9;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DIV_W      = 17;
    localparam int unsigned DIV_STAGES = 4;

    localparam logic [COLOR_W-1:0]   HUE_HALF_WRAP = 8'd180;
    localparam logic [HUE_DEG_W-1:0] HUE_FULL_DEG  = 9'd360;
    localparam logic [HUE_DEG_W-1:0] HUE_HALF_DEG  = 9'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE  = 3'd0,
        REG_CENTRE_HUE     = 3'd1,
        REG_HUE_TOLERANCE  = 3'd2,
        REG_MIN_SATURATION = 3'd3,
        REG_MAX_SATURATION = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                 filter_enable;
        logic [HUE_DEG_W-1:0] centre_hue;
        logic [COLOR_W-1:0]   hue_tolerance;
        logic [COLOR_W-1:0]   min_saturation;
        logic [COLOR_W-1:0]   max_saturation;
    } t_cfg;

    typedef struct packed {
        logic [DIV_W-1:0]   rem;
        logic [DIV_W-1:0]   dsh;
        logic [COLOR_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic row_valid;
        logic grey;
    } t_side;

endpackage

`default_nettype wire

/* rtl/hsog_prep.sv */
// ----------------------------------------------------------------------------
// hsog_prep
// three-stage front end: max/min, channel pick, hue and saturation dividends
// ----------------------------------------------------------------------------
`default_nettype none

module hsog_prep (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_vld,
    input  wire  [hsog_pkg::COLOR_W-1:0]   i_blue,
    input  wire  [hsog_pkg::COLOR_W-1:0]   i_green,
    input  wire  [hsog_pkg::COLOR_W-1:0]   i_red,
    input  wire                            i_row_valid,
    output logic                           o_vld,
    output hsog_pkg::t_side                o_side,
    output hsog_pkg::t_div                 o_sat,
    output hsog_pkg::t_div                 o_hue
);
    import hsog_pkg::*;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_chan;

    // stage a
    logic [COLOR_W-1:0]  mx, mn;
    logic [COLOR_W:0]    sum;
    logic [COLOR_W-1:0]  n_a_d, n_a_den;
    logic signed [8:0]   n_a_num;
    t_chan               n_a_chan;

    logic                r_a_vld;
    logic [COLOR_W-1:0]  r_a_d, r_a_den;
    logic signed [8:0]   r_a_num;
    t_chan               r_a_chan;
    t_side               r_a_side;

    // stage b
    logic signed [17:0]  num30, off_d;
    logic [16:0]         n_b_satnum;
    logic signed [17:0]  n_b_n;

    logic                r_b_vld;
    logic signed [17:0]  r_b_n;
    logic [COLOR_W-1:0]  r_b_d, r_b_den;
    logic [16:0]         r_b_satnum;
    t_side               r_b_side;

    // stage c
    logic signed [17:0]  n_fix;
    logic [16:0]         n_c_huenum;

    logic                r_c_vld;
    t_side               r_c_side;
    t_div                r_c_sat, r_c_hue;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        sum   = {1'b0, mx} + {1'b0, mn};
        n_a_d = mx - mn;
        if (sum < 9'd255) begin
            n_a_den = sum[COLOR_W-1:0];
        end else begin
            n_a_den = 8'(10'd510 - {1'b0, sum});
        end
        if (mx == i_red) begin
            n_a_chan = CH_RED;
            n_a_num  = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (mx == i_green) begin
            n_a_chan = CH_GREEN;
            n_a_num  = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a_chan = CH_BLUE;
            n_a_num  = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_comb begin
        num30 = $signed({{9{r_a_num[8]}}, r_a_num}) * 18'sd30;
        case (r_a_chan)
            CH_GREEN: off_d = $signed(18'(r_a_d) * 18'd60);
            CH_BLUE:  off_d = $signed(18'(r_a_d) * 18'd120);
            default:  off_d = 18'sd0;
        endcase
        n_b_n      = num30 + off_d;
        n_b_satnum = 17'(r_a_d) * 17'd510 + 17'(r_a_den);
    end

    // negative hue wraps by a full turn (180 in half-degree units), then 2n + d for rounding
    always_comb begin
        if (r_b_n[17]) begin
            n_fix = r_b_n + $signed({1'b0, 17'(r_b_d) * 17'd180});
        end else begin
            n_fix = r_b_n;
        end
        n_c_huenum = {n_fix[15:0], 1'b0} + 17'(r_b_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_d              <= n_a_d;
        r_a_den            <= n_a_den;
        r_a_num            <= n_a_num;
        r_a_chan           <= n_a_chan;
        r_a_side.row_valid <= i_row_valid;
        r_a_side.grey      <= (n_a_d == '0);

        r_b_n      <= n_b_n;
        r_b_d      <= r_a_d;
        r_b_den    <= r_a_den;
        r_b_satnum <= n_b_satnum;
        r_b_side   <= r_a_side;

        r_c_side    <= r_b_side;
        r_c_sat.rem <= r_b_satnum;
        r_c_sat.dsh <= {1'b0, r_b_den, 8'b0};
        r_c_sat.quo <= '0;
        r_c_hue.rem <= n_c_huenum;
        r_c_hue.dsh <= {1'b0, r_b_d, 8'b0};
        r_c_hue.quo <= '0;
    end

    assign o_vld  = r_c_vld;
    assign o_side = r_c_side;
    assign o_sat  = r_c_sat;
    assign o_hue  = r_c_hue;

endmodule

`default_nettype wire

/* rtl/hsog_div_stage.sv */
// ----------------------------------------------------------------------------
// hsog_div_stage
// one register stage of the two restoring dividers, two quotient bits each
// ----------------------------------------------------------------------------
`default_nettype none

module hsog_div_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_vld,
    input  hsog_pkg::t_side       i_side,
    input  hsog_pkg::t_div        i_sat,
    input  hsog_pkg::t_div        i_hue,
    output logic                  o_vld,
    output hsog_pkg::t_side       o_side,
    output hsog_pkg::t_div        o_sat,
    output hsog_pkg::t_div        o_hue
);
    import hsog_pkg::*;

    function automatic t_div div_step(input t_div x);
        t_div y;
        y = x;
        if (x.rem >= x.dsh) begin
            y.rem = x.rem - x.dsh;
            y.quo = {x.quo[COLOR_W-2:0], 1'b1};
        end else begin
            y.quo = {x.quo[COLOR_W-2:0], 1'b0};
        end
        y.dsh = x.dsh >> 1;
        return y;
    endfunction

    logic  r_vld;
    t_side r_side;
    t_div  r_sat, r_hue;
    t_div  n_sat, n_hue;

    always_comb begin
        n_sat = div_step(div_step(i_sat));
        n_hue = div_step(div_step(i_hue));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_sat  <= n_sat;
        r_hue  <= n_hue;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_sat  = r_sat;
    assign o_hue  = r_hue;

endmodule

`default_nettype wire

/* rtl/hsog_gate.sv */
// ----------------------------------------------------------------------------
// hsog_gate
// hue wrap, circular hue distance and the final keep decision
// ----------------------------------------------------------------------------
`default_nettype none

module hsog_gate (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_vld,
    input  hsog_pkg::t_side               i_side,
    input  wire  [hsog_pkg::COLOR_W-1:0]  i_sat_q,
    input  wire  [hsog_pkg::COLOR_W-1:0]  i_hue_q,
    input  hsog_pkg::t_cfg                i_cfg,
    output logic                          o_done,
    output logic                          o_keep
);
    import hsog_pkg::*;

    logic [COLOR_W-1:0]   hh, sat;
    logic [HUE_DEG_W-1:0] deg, centre, diff;
    logic [COLOR_W-1:0]   n_dist;

    logic                 r_g_vld;
    logic [COLOR_W-1:0]   r_g_dist, r_g_sat;
    logic                 r_g_row_valid;

    logic                 pass;
    logic                 r_done, r_keep;

    always_comb begin
        hh  = i_side.grey ? '0 : i_hue_q;
        sat = i_side.grey ? '0 : i_sat_q;
        if (hh >= HUE_HALF_WRAP) begin
            hh = hh - HUE_HALF_WRAP;
        end
        deg = {hh, 1'b0};
        if (i_cfg.centre_hue >= HUE_FULL_DEG) begin
            centre = i_cfg.centre_hue - HUE_FULL_DEG;
        end else begin
            centre = i_cfg.centre_hue;
        end
        diff = (deg > centre) ? deg - centre : centre - deg;
        if (diff > HUE_HALF_DEG) begin
            n_dist = 8'(HUE_FULL_DEG - diff);
        end else begin
            n_dist = diff[COLOR_W-1:0];
        end
    end

    always_comb begin
        pass = (r_g_dist <= i_cfg.hue_tolerance) &&
               (r_g_sat <= i_cfg.max_saturation) &&
               (r_g_sat >= i_cfg.min_saturation);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_g_vld <= i_vld;
            r_done  <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_dist      <= n_dist;
        r_g_sat       <= sat;
        r_g_row_valid <= i_side.row_valid;
        r_keep        <= i_cfg.filter_enable ? (pass & r_g_row_valid) : r_g_row_valid;
    end

    assign o_done = r_done;
    assign o_keep = r_keep;

endmodule

`default_nettype wire

/* rtl/hue_saturation_object_gate_top.sv */
// ----------------------------------------------------------------------------
// hue_saturation_object_gate_top
// keeps or drops a detected object by the hue and saturation of its colour
// ----------------------------------------------------------------------------
// usage
//   request channel: blue, green, red means and row_valid; taken at a clock
//   edge with start high and busy low. busy is low whenever reset is released,
//   so one request can enter every cycle.
//   result channel: o_keep is shown for one cycle with o_done high, in request
//   order; the receiver cannot stall and needs none.
//   latency is set by the pipeline: three front stages (max/min, dividends,
//   hue wrap), four divider stages of two quotient bits each for the hue and
//   saturation ratios, and two gate stages (hue distance, compares).
//   config: write i_cfg_idx / i_cfg_data with i_cfg_we high, one edge each,
//   only while no request is in flight.
//   reset: synchronous, active low; clears all valid bits and sets the
//   registers to filter off, centre 0, tolerance 180, saturation 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module hue_saturation_object_gate_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [hsog_pkg::COLOR_W-1:0]      i_blue,
    input  wire  [hsog_pkg::COLOR_W-1:0]      i_green,
    input  wire  [hsog_pkg::COLOR_W-1:0]      i_red,
    input  wire                               i_row_valid,
    output logic                              o_done,
    output logic                              o_keep,
    input  wire                               i_cfg_we,
    input  wire  [hsog_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [hsog_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hsog_pkg::*;

    t_cfg  r_cfg;
    logic  accept;

    logic  vld  [0:DIV_STAGES];
    t_side side [0:DIV_STAGES];
    t_div  sat  [0:DIV_STAGES];
    t_div  hue  [0:DIV_STAGES];

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_enable  <= 1'b0;
            r_cfg.centre_hue     <= '0;
            r_cfg.hue_tolerance  <= 8'd180;
            r_cfg.min_saturation <= '0;
            r_cfg.max_saturation <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FILTER_ENABLE:  r_cfg.filter_enable  <= i_cfg_data[0];
                REG_CENTRE_HUE:     r_cfg.centre_hue     <= i_cfg_data;
                REG_HUE_TOLERANCE:  r_cfg.hue_tolerance  <= i_cfg_data[COLOR_W-1:0];
                REG_MIN_SATURATION: r_cfg.min_saturation <= i_cfg_data[COLOR_W-1:0];
                REG_MAX_SATURATION: r_cfg.max_saturation <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    hsog_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (accept),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_row_valid (i_row_valid),
        .o_vld       (vld[0]),
        .o_side      (side[0]),
        .o_sat       (sat[0]),
        .o_hue       (hue[0])
    );

    for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
        hsog_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[gi]),
            .i_side  (side[gi]),
            .i_sat   (sat[gi]),
            .i_hue   (hue[gi]),
            .o_vld   (vld[gi+1]),
            .o_side  (side[gi+1]),
            .o_sat   (sat[gi+1]),
            .o_hue   (hue[gi+1])
        );
    end

    hsog_gate u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[DIV_STAGES]),
        .i_side  (side[DIV_STAGES]),
        .i_sat_q (sat[DIV_STAGES].quo),
        .i_hue_q (hue[DIV_STAGES].quo),
        .i_cfg   (r_cfg),
        .o_done  (o_done),
        .o_keep  (o_keep)
    );

endmodule

`default_nettype wire

/* rtl/hsog_checker.sv */
// ----------------------------------------------------------------------------
// hsog_checker
// port-level checks of request to result timing and validity
// ----------------------------------------------------------------------------
`default_nettype none

module hsog_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire i_row_valid,
    input wire o_done,
    input wire o_keep
);
    localparam int unsigned LATENCY = 9;

    // every request gives its result after a fixed latency
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("request without result");

    // no result without a matching request
    a_done_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // an object kept must have been valid on entry
    a_keep_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_keep) |-> $past(i_row_valid, LATENCY))
        else $error("kept object was not valid");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

endmodule

bind hue_saturation_object_gate_top hsog_checker u_hsog_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_row_valid (i_row_valid),
    .o_done      (o_done),
    .o_keep      (o_keep)
);

`default_nettype wire

/* dv/tb_hue_saturation_object_gate_top.sv */
// ----------------------------------------------------------------------------
// tb_hue_saturation_object_gate_top
// self-checking bench for the hue and saturation object gate: a queue-fed
// driver sends colour requests with random idle bursts, a bit-exact keep
// predictor tracks the register settings, and a monitor checks every done
// strobe against the oldest predicted keep bit
// ----------------------------------------------------------------------------

module tb_hue_saturation_object_gate_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hsog_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               row_valid;
    } object_req_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [COLOR_W-1:0]    i_blue      = '0;
    logic [COLOR_W-1:0]    i_green     = '0;
    logic [COLOR_W-1:0]    i_red       = '0;
    logic                  i_row_valid = 1'b0;
    logic                  o_done;
    logic                  o_keep;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    object_req_t pending_reqs[$];
    logic        keep_expected[$];
    t_cfg        gate_cfg;
    int          mismatch_count = 0;
    int          idle_left      = 0;
    int          gap_pct        = 0;

    hue_saturation_object_gate_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_row_valid (i_row_valid),
        .o_done      (o_done),
        .o_keep      (o_keep),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int round_ratio(input int num, input int den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic predict_keep(input object_req_t req);
        int r, g, b, mx, mn, d, sum, sat, num, off, n, h, hue_deg, ctr, a, hue_dist;
        r = req.red;
        g = req.green;
        b = req.blue;
        if (!gate_cfg.filter_enable)
            return req.row_valid;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) begin
            h   = 0;
            sat = 0;
        end else begin
            sum = mx + mn;
            if (sum < 255)
                sat = round_ratio(255 * d, sum);
            else
                sat = round_ratio(255 * d, 510 - sum);
            if (mx == r) begin
                num = g - b;
                off = 0;
            end else if (mx == g) begin
                num = b - r;
                off = 60;
            end else begin
                num = r - g;
                off = 120;
            end
            n = 30 * num + off * d;
            if (n < 0)
                n = n + 180 * d;
            h = round_ratio(n, d);
            if (h >= 180)
                h = h - 180;
        end
        hue_deg  = 2 * h;
        ctr      = int'(gate_cfg.centre_hue) % 360;
        a        = (hue_deg > ctr) ? hue_deg - ctr : ctr - hue_deg;
        hue_dist = (a > 180) ? 360 - a : a;
        if (hue_dist > int'(gate_cfg.hue_tolerance) || sat > int'(gate_cfg.max_saturation)
                || sat < int'(gate_cfg.min_saturation))
            return 1'b0;
        return req.row_valid;
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive
        object_req_t req;
        logic        fire;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            fire = start && !busy;
            if (fire) begin
                req = '{blue: i_blue, green: i_green, red: i_red, row_valid: i_row_valid};
                keep_expected.push_back(predict_keep(req));
            end
            if (start && !fire) begin
                start <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end else if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
                req         = pending_reqs.pop_front();
                start       <= 1'b1;
                i_blue      <= req.blue;
                i_green     <= req.green;
                i_red       <= req.red;
                i_row_valid <= req.row_valid;
            end else begin
                start <= 1'b0;
                if (pending_reqs.size() > 0)
                    idle_left <= $urandom_range(19, 1) - 1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        logic want;
        if (i_rst_n && o_done) begin
            if (keep_expected.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                $display("%0t unexpected result: expected none, actual keep %0b", $time, o_keep);
            end else begin
                want = keep_expected.pop_front();
                if (o_keep !== want) begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t keep mismatch: expected %0b, actual %0b", $time, want, o_keep);
                end
            end
        end
    end

    task automatic write_gate_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_FILTER_ENABLE:  gate_cfg.filter_enable  = value[0];
            REG_CENTRE_HUE:     gate_cfg.centre_hue     = value[HUE_DEG_W-1:0];
            REG_HUE_TOLERANCE:  gate_cfg.hue_tolerance  = value[COLOR_W-1:0];
            REG_MIN_SATURATION: gate_cfg.min_saturation = value[COLOR_W-1:0];
            REG_MAX_SATURATION: gate_cfg.max_saturation = value[COLOR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_gate(input logic en, input int centre, input int tol,
                            input int smin, input int smax);
        write_gate_reg(REG_FILTER_ENABLE, CFG_DATA_W'(en));
        write_gate_reg(REG_CENTRE_HUE, CFG_DATA_W'(centre));
        write_gate_reg(REG_HUE_TOLERANCE, CFG_DATA_W'(tol));
        write_gate_reg(REG_MIN_SATURATION, CFG_DATA_W'(smin));
        write_gate_reg(REG_MAX_SATURATION, CFG_DATA_W'(smax));
    endtask

    task automatic push_req(input int b, input int g, input int r, input logic v);
        pending_reqs.push_back('{blue: COLOR_W'(b), green: COLOR_W'(g),
                                 red: COLOR_W'(r), row_valid: v});
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || keep_expected.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic push_random_req();
        int b, g, r, lo, base;
        logic v;
        b = $urandom_range(255);
        g = $urandom_range(255);
        r = $urandom_range(255);
        v = ($urandom_range(3) != 0);
        case ($urandom_range(9))
            0: begin
                g = b;
                r = b;
            end
            1, 2: begin
                lo = $urandom_range(255);
                case ($urandom_range(2))
                    0: begin g = r; b = (lo < r) ? lo : r; end
                    1: begin b = r; g = (lo < r) ? lo : r; end
                    default: begin b = g; r = (lo < g) ? lo : g; end
                endcase
            end
            3: begin
                base = $urandom_range(247);
                b = base + $urandom_range(8);
                g = base + $urandom_range(8);
                r = base + $urandom_range(8);
            end
            default: ;
        endcase
        push_req(b, g, r, v);
    endtask

    function automatic int pick_hue_centre();
        case ($urandom_range(7))
            0: return 0;
            1: return 359;
            2: return 360;
            3: return 511;
            default: return $urandom_range(511);
        endcase
    endfunction

    function automatic int pick_tolerance();
        case ($urandom_range(7))
            0: return 0;
            1: return 180;
            2: return 181;
            3: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial begin : stimulus
        int lo, hi, tmp;
        gate_cfg = '{filter_enable: 1'b0, centre_hue: '0, hue_tolerance: 8'd180,
                     min_saturation: 8'd0, max_saturation: 8'd255};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gap_pct = 20;

        // reset settings, gate off
        push_req(0, 0, 0, 1'b0);
        push_req(255, 255, 255, 1'b1);
        wait_drained();

        // gate on with reset hue and saturation limits
        write_gate_reg(REG_FILTER_ENABLE, CFG_DATA_W'(1));
        push_req(0, 0, 255, 1'b1);
        push_req(255, 0, 0, 1'b1);
        push_req(128, 128, 128, 1'b1);
        push_req(0, 255, 0, 1'b0);
        wait_drained();

        // zero tolerance around red
        set_gate(1'b1, 0, 0, 0, 255);
        push_req(0, 0, 0, 1'b1);
        push_req(0, 0, 255, 1'b1);
        push_req(1, 0, 255, 1'b1);
        push_req(0, 255, 0, 1'b1);
        push_req(0, 255, 255, 1'b1);
        push_req(255, 0, 255, 1'b1);
        push_req(255, 255, 0, 1'b1);
        push_req(0, 1, 60, 1'b1);
        push_req(0, 0, 1, 1'b1);
        push_req(254, 255, 255, 1'b1);
        wait_drained();

        // min above max
        set_gate(1'b1, 359, 180, 255, 0);
        push_req(0, 0, 255, 1'b1);
        push_req(7, 7, 7, 1'b1);
        push_req(255, 0, 0, 1'b1);
        wait_drained();

        // centre beyond 359, tolerance beyond 180
        set_gate(1'b1, 511, 255, 128, 128);
        push_req(64, 0, 255, 1'b1);
        push_req(0, 191, 191, 1'b1);
        push_req(200, 10, 90, 1'b0);
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            lo = $urandom_range(3) == 0 ? 0 : $urandom_range(255);
            hi = $urandom_range(3) == 0 ? 255 : $urandom_range(255);
            if (lo > hi && $urandom_range(3) != 0) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            case (p)
                0:       set_gate(1'b1, 0, 0, 0, 255);
                1:       set_gate(1'b1, 359, 180, 255, 0);
                2:       set_gate(1'b1, 511, 255, 0, 255);
                3, 7:    set_gate(1'b0, pick_hue_centre(), pick_tolerance(), lo, hi);
                default: set_gate(1'b1, pick_hue_centre(), pick_tolerance(), lo, hi);
            endcase
            if (p >= 10)
                gap_pct = 0;
            else
                gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
            for (int k = 0; k < 120; k++)
                push_random_req();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[hue_saturation_object_gate_top] OK");
        end else begin
            $display("[hue_saturation_object_gate_top] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("[hue_saturation_object_gate_top] ERROR");
        $finish;
    end

endmodule
